@@ rtl/sample_scope_resampler_unit_macros.svh @@
// ============================================================================
// Sample scope resampler assertion macros
// Clocked, reset-qualified property forms used by the top-level unit.
// ============================================================================
`ifndef SAMPLE_SCOPE_RESAMPLER_UNIT_MACROS_SVH
`define SAMPLE_SCOPE_RESAMPLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ssr_pkg.sv @@
// ============================================================================
// Sample scope resampler package
// Sizes, codes, payload types and control bundles shared by the block.
// ============================================================================
`timescale 1ns / 1ps

package ssr_pkg;

    // Storage sizes (sample depth is a power of two: read addresses wrap)
    localparam int CHANNELS     = 64;
    localparam int SAMPLE_DEPTH = 16384;
    localparam int CHAN_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);

    // Field widths
    localparam int ADDR_W   = 14;
    localparam int WORD_W   = 16;
    localparam int CHAN_W   = 6;
    localparam int PERIOD_W = 16;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 15;

    // Position arithmetic
    localparam int FRAC_BITS = 5;
    localparam int POS_W     = 23;
    localparam int INT_W     = POS_W - FRAC_BITS;
    localparam int BOUND_W   = LEN_W + FRAC_BITS;
    localparam int STEP_W    = 18;
    localparam int SUM_W     = POS_W + 1;
    localparam int WSUM_W    = SUM_W + 1;

    localparam logic [STEP_W-1:0] STEP_NUMERATOR = STEP_W'(13696 << 4);
    localparam int DIV_CNT_W = $clog2(STEP_W);

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_READY  = 3'd5;

    typedef struct packed {
        logic                      func;
        logic [ADDR_W-1:0]         mem_address;
        logic signed [WORD_W-1:0]  mem_word;
        logic [CHAN_W-1:0]         channel;
        logic [PERIOD_W-1:0]       period;
        logic                      first_point;
        logic                      retrigger;
    } in_item_t;

    typedef struct packed {
        logic signed [BYTE_W-1:0]  sample_value;
        logic                      ran_out;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] sample_length;
        logic [LEN_W-1:0] loop_start;
        logic [LEN_W-1:0] loop_end;
        logic             loop_enabled;
        logic             wide_samples;
        logic             sample_ready;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_DROP,
        OP_NO_SAMPLE,
        OP_ZERO_PERIOD,
        OP_POINT
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [ADDR_W-1:0]    mem_address;
        logic [WORD_W-1:0]    mem_word;
        logic [CHAN_W-1:0]    channel;
        logic [PERIOD_W-1:0]  period;
        logic                 first_point;
        logic                 retrigger;
    } q_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic                 we;
        logic [CHAN_AW-1:0]   waddr;
        logic [POS_W-1:0]     wdata;
        logic                 re;
        logic [CHAN_AW-1:0]   raddr;
    } pos_ram_req_t;

    typedef struct packed {
        logic                 we;
        logic [SAMPLE_AW-1:0] waddr;
        logic [WORD_W-1:0]    wdata;
        logic                 re;
        logic [SAMPLE_AW-1:0] raddr;
    } smp_ram_req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_POS,
        BK_DIVIDE,
        BK_SUM,
        BK_WRAP,
        BK_JOIN,
        BK_FINAL,
        BK_EMIT
    } back_state_t;

endpackage

@@ rtl/ssr_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
`timescale 1ns / 1ps

module ssr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ssr_front.sv @@
// ============================================================================
// Sample scope resampler front end
// Accept input transfers, classify them and hold them in a short queue.
// ============================================================================
`timescale 1ns / 1ps

module ssr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ssr_pkg::in_item_t  in_item,
    input  ssr_pkg::cfg_t      cfg,
    output logic               head_valid,
    output ssr_pkg::q_entry_t  head,
    input  logic               pop
);

    ssr_pkg::q_entry_t               slot_reg [ssr_pkg::QUEUE_DEPTH];
    ssr_pkg::q_entry_t               entry_new;
    logic [ssr_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [ssr_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [ssr_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [ssr_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [ssr_pkg::QUEUE_AW:0]      count_reg;
    logic [ssr_pkg::QUEUE_AW:0]      count_next;
    logic                            push;

    // Classify while the configuration is stable
    always_comb
    begin
        entry_new.mem_address = in_item.mem_address;
        entry_new.mem_word    = in_item.mem_word;
        entry_new.channel     = in_item.channel;
        entry_new.period      = in_item.period;
        entry_new.first_point = in_item.first_point;
        entry_new.retrigger   = in_item.retrigger;
        if (!in_item.func)
        begin
            if (32'(in_item.mem_address) >= 32'(ssr_pkg::SAMPLE_DEPTH))
            begin
                entry_new.kind = ssr_pkg::OP_DROP;
            end
            else
            begin
                entry_new.kind = ssr_pkg::OP_WRITE;
            end
        end
        else if (!cfg.sample_ready || (cfg.sample_length == '0)
                 || (32'(in_item.channel) >= 32'(ssr_pkg::CHANNELS)))
        begin
            entry_new.kind = ssr_pkg::OP_NO_SAMPLE;
        end
        else if (in_item.period == '0)
        begin
            entry_new.kind = ssr_pkg::OP_ZERO_PERIOD;
        end
        else
        begin
            entry_new.kind = ssr_pkg::OP_POINT;
        end
    end

    assign in_stall   = (count_reg == (ssr_pkg::QUEUE_AW + 1)'(ssr_pkg::QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_new;
        end
    end

endmodule

@@ rtl/ssr_div.sv @@
// ============================================================================
// Sample scope resampler step divider
// Restoring divider: the fixed step numerator over the period, one bit a cycle.
// ============================================================================
`timescale 1ns / 1ps

module ssr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ssr_pkg::PERIOD_W-1:0]  divisor,
    output logic [ssr_pkg::STEP_W-1:0]    quotient,
    output ssr_pkg::div_status_t          status
);

    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;
    logic [ssr_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [ssr_pkg::DIV_CNT_W-1:0]   cnt_next;
    logic [ssr_pkg::PERIOD_W-1:0]    div_reg;
    logic [ssr_pkg::PERIOD_W-1:0]    rem_reg;
    logic [ssr_pkg::STEP_W-1:0]      quo_reg;
    logic [ssr_pkg::PERIOD_W:0]      trial;
    logic                            fits;

    // Bring down the next numerator bit and try the subtraction
    assign trial = {rem_reg, ssr_pkg::STEP_NUMERATOR[cnt_reg]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ssr_pkg::DIV_CNT_W'(ssr_pkg::STEP_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? ssr_pkg::PERIOD_W'(trial - {1'b0, div_reg})
                            : trial[ssr_pkg::PERIOD_W-1:0];
            quo_reg <= {quo_reg[ssr_pkg::STEP_W-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/ssr_back.sv @@
// ============================================================================
// Sample scope resampler back end
// Sequence memory writes and display points; hold the result register.
// ============================================================================
`timescale 1ns / 1ps

module ssr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssr_pkg::cfg_t                 cfg,
    input  logic                          head_valid,
    input  ssr_pkg::q_entry_t             head,
    output logic                          pop,
    output logic                          div_start,
    output logic [ssr_pkg::PERIOD_W-1:0]  div_divisor,
    input  ssr_pkg::div_status_t          div_status,
    input  logic [ssr_pkg::STEP_W-1:0]    div_quotient,
    output ssr_pkg::pos_ram_req_t         pos_req,
    input  logic [ssr_pkg::POS_W-1:0]     pos_rdata,
    output ssr_pkg::smp_ram_req_t         smp_req,
    input  logic [ssr_pkg::WORD_W-1:0]    smp_rdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ssr_pkg::out_item_t            out_item
);

    ssr_pkg::back_state_t              state_reg;
    ssr_pkg::back_state_t              state_next;
    ssr_pkg::q_entry_t                 cur_reg;
    logic                              pv_reg;
    logic [ssr_pkg::POS_W-1:0]         pos0_reg;
    logic [ssr_pkg::SUM_W-1:0]         sum_reg;
    logic [ssr_pkg::SUM_W-1:0]         diff_reg;
    logic [ssr_pkg::WSUM_W-1:0]        wsum_reg;
    logic                              le_lps_reg;
    logic                              ge_lpe_reg;
    logic                              le_end_reg;
    ssr_pkg::out_item_t                res_reg;
    ssr_pkg::out_item_t                res_final;
    logic [ssr_pkg::CHANNELS-1:0]      pos_valid_reg;
    logic [ssr_pkg::CHANNELS-1:0]      pos_valid_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    ssr_pkg::out_item_t                out_reg;

    logic [ssr_pkg::BOUND_W-1:0]       lps;
    logic [ssr_pkg::BOUND_W-1:0]       lpe;
    logic [ssr_pkg::BOUND_W-1:0]       lend;
    logic [ssr_pkg::POS_W-1:0]         pos_cur;
    logic                              first_reset;
    logic [ssr_pkg::BYTE_W-1:0]        byte_sel;
    logic [ssr_pkg::POS_W-1:0]         pos_new;
    logic                              out_free;
    logic                              load_out;

    assign lps  = {cfg.loop_start, {ssr_pkg::FRAC_BITS{1'b0}}};
    assign lpe  = {cfg.loop_end, {ssr_pkg::FRAC_BITS{1'b0}}};
    assign lend = {cfg.sample_length, {ssr_pkg::FRAC_BITS{1'b0}}};

    // A channel never written reads as position zero
    assign pos_cur     = pv_reg ? pos_rdata : '0;
    assign first_reset = cur_reg.first_point
                         && (cur_reg.retrigger
                             || (pos_cur[ssr_pkg::POS_W-1:ssr_pkg::FRAC_BITS]
                                 >= ssr_pkg::INT_W'(cfg.sample_length)));

    assign byte_sel = cfg.wide_samples ? smp_rdata[ssr_pkg::WORD_W-1 -: ssr_pkg::BYTE_W]
                                       : smp_rdata[ssr_pkg::BYTE_W-1:0];

    // New position: wrap a looped sample, hold an ended one-shot
    always_comb
    begin
        if (cfg.loop_enabled)
        begin
            if (!le_lps_reg && ge_lpe_reg)
            begin
                if (wsum_reg >= ssr_pkg::WSUM_W'(lpe))
                begin
                    pos_new = ssr_pkg::POS_W'(lps);
                end
                else
                begin
                    pos_new = wsum_reg[ssr_pkg::POS_W-1:0];
                end
            end
            else
            begin
                pos_new = sum_reg[ssr_pkg::POS_W-1:0];
            end
            res_final.sample_value = byte_sel;
            res_final.ran_out      = 1'b0;
        end
        else if (le_end_reg)
        begin
            pos_new                = sum_reg[ssr_pkg::POS_W-1:0];
            res_final.sample_value = byte_sel;
            res_final.ran_out      = 1'b0;
        end
        else
        begin
            pos_new                = pos0_reg;
            res_final.sample_value = '0;
            res_final.ran_out      = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssr_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.kind) inside
                        ssr_pkg::OP_NO_SAMPLE, ssr_pkg::OP_ZERO_PERIOD:
                            state_next = ssr_pkg::BK_EMIT;
                        ssr_pkg::OP_POINT:
                            state_next = ssr_pkg::BK_POS;
                        default:
                            state_next = ssr_pkg::BK_IDLE;
                    endcase
                end
            end
            ssr_pkg::BK_POS:    state_next = ssr_pkg::BK_DIVIDE;
            ssr_pkg::BK_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = ssr_pkg::BK_SUM;
                end
            end
            ssr_pkg::BK_SUM:    state_next = ssr_pkg::BK_WRAP;
            ssr_pkg::BK_WRAP:   state_next = ssr_pkg::BK_JOIN;
            ssr_pkg::BK_JOIN:   state_next = ssr_pkg::BK_FINAL;
            ssr_pkg::BK_FINAL:  state_next = ssr_pkg::BK_EMIT;
            ssr_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ssr_pkg::BK_IDLE;
                end
            end
            default:            state_next = ssr_pkg::BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        pop           = 1'b0;
        div_start     = 1'b0;
        div_divisor   = head.period;
        pos_req.we    = 1'b0;
        pos_req.waddr = ssr_pkg::CHAN_AW'(cur_reg.channel);
        pos_req.wdata = pos_new;
        pos_req.re    = 1'b0;
        pos_req.raddr = ssr_pkg::CHAN_AW'(head.channel);
        smp_req.we    = 1'b0;
        smp_req.waddr = ssr_pkg::SAMPLE_AW'(head.mem_address);
        smp_req.wdata = head.mem_word;
        smp_req.re    = 1'b0;
        smp_req.raddr = pos0_reg[ssr_pkg::FRAC_BITS +: ssr_pkg::SAMPLE_AW];
        load_out      = 1'b0;
        unique case (state_reg)
            ssr_pkg::BK_IDLE:
            begin
                pop        = head_valid;
                div_start  = head_valid && (head.kind == ssr_pkg::OP_POINT);
                pos_req.re = head_valid && (head.kind == ssr_pkg::OP_POINT);
                smp_req.we = head_valid && (head.kind == ssr_pkg::OP_WRITE);
            end
            ssr_pkg::BK_SUM:   smp_req.re = 1'b1;
            ssr_pkg::BK_FINAL: pos_req.we = 1'b1;
            ssr_pkg::BK_EMIT:  load_out   = out_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        pos_valid_next = pos_valid_reg;
        if (pos_req.we)
        begin
            pos_valid_next[pos_req.waddr] = 1'b1;
        end
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssr_pkg::BK_IDLE;
            pos_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_valid_reg <= pos_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg              <= head;
            pv_reg               <= pos_valid_reg[ssr_pkg::CHAN_AW'(head.channel)];
            res_reg.sample_value <= '0;
            res_reg.ran_out      <= (head.kind == ssr_pkg::OP_NO_SAMPLE);
        end
        if (state_reg == ssr_pkg::BK_POS)
        begin
            pos0_reg <= first_reset ? '0 : pos_cur;
        end
        if (state_reg == ssr_pkg::BK_SUM)
        begin
            sum_reg <= ssr_pkg::SUM_W'(pos0_reg) + ssr_pkg::SUM_W'(div_quotient);
        end
        if (state_reg == ssr_pkg::BK_WRAP)
        begin
            le_lps_reg <= (sum_reg <= ssr_pkg::SUM_W'(lps));
            ge_lpe_reg <= (sum_reg >= ssr_pkg::SUM_W'(lpe));
            le_end_reg <= (sum_reg <= ssr_pkg::SUM_W'(lend));
            diff_reg   <= sum_reg - ssr_pkg::SUM_W'(lpe);
        end
        if (state_reg == ssr_pkg::BK_JOIN)
        begin
            wsum_reg <= ssr_pkg::WSUM_W'(lps) + ssr_pkg::WSUM_W'(diff_reg);
        end
        if (state_reg == ssr_pkg::BK_FINAL)
        begin
            res_reg <= res_final;
        end
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

@@ rtl/sample_scope_resampler_unit.sv @@
// ============================================================================
// Sample scope resampler unit
// Per-channel playback positions over one loaded sample, for display points.
// ============================================================================
// In the back end a memory write is done in the idle state as it is popped; a
// point with no sample or a zero period goes to the emit state to wait for the
// output register; on its pop a normal point starts the divider, which forms
// step = 219136 / period one quotient bit a cycle, waits for its done flag, then
// goes through the sum, wrap, join, final and emit states to update the position
// and hand off to the output register. A two-entry queue sits in front, so up to
// two transfers are taken while the back end is busy or a result waits to be
// taken. Channel positions start at zero through per-channel valid bits, so
// there is no clearing pass after reset; sample memory holds garbage until written.
// ============================================================================
`timescale 1ns / 1ps

module sample_scope_resampler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssr_pkg::LEN_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ssr_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ssr_pkg::out_item_t             out_item
);

`include "sample_scope_resampler_unit_macros.svh"

    ssr_pkg::cfg_t                   cfg_reg;
    ssr_pkg::cfg_t                   cfg_next;

    logic                            q_head_valid;
    ssr_pkg::q_entry_t               q_head;
    logic                            q_pop;

    logic                            div_start;
    logic [ssr_pkg::PERIOD_W-1:0]    div_divisor;
    logic [ssr_pkg::STEP_W-1:0]      div_quotient;
    ssr_pkg::div_status_t            div_status;

    ssr_pkg::pos_ram_req_t           pos_req;
    logic [ssr_pkg::POS_W-1:0]       pos_rdata;
    ssr_pkg::smp_ram_req_t           smp_req;
    logic [ssr_pkg::WORD_W-1:0]      smp_rdata;

    // Configuration registers: the user must write them only while the block is
    // idle (not enforced here), so the front and back end read them directly.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ssr_pkg::CFG_SAMPLE_LENGTH: cfg_next.sample_length = cfg_data;
                ssr_pkg::CFG_LOOP_START:    cfg_next.loop_start    = cfg_data;
                ssr_pkg::CFG_LOOP_END:      cfg_next.loop_end      = cfg_data;
                ssr_pkg::CFG_LOOP_ENABLED:  cfg_next.loop_enabled  = cfg_data[0];
                ssr_pkg::CFG_WIDE_SAMPLES:  cfg_next.wide_samples  = cfg_data[0];
                ssr_pkg::CFG_SAMPLE_READY:  cfg_next.sample_ready  = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: take transfers, sort them into writes, dropped writes,
    // silent points and real points, and queue them in order.
    ssr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    // Step divider, started by the back end once per real point
    ssr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // Back end: one queued transfer at a time, in queue order, so a point
    // always sees every sample write that went in ahead of it.
    ssr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (q_head_valid),
        .head         (q_head),
        .pop          (q_pop),
        .div_start    (div_start),
        .div_divisor  (div_divisor),
        .div_status   (div_status),
        .div_quotient (div_quotient),
        .pos_req      (pos_req),
        .pos_rdata    (pos_rdata),
        .smp_req      (smp_req),
        .smp_rdata    (smp_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

    // Channel position store
    ssr_ram #(
        .WIDTH (ssr_pkg::POS_W),
        .DEPTH (ssr_pkg::CHANNELS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_req.we),
        .waddr (pos_req.waddr),
        .wdata (pos_req.wdata),
        .re    (pos_req.re),
        .raddr (pos_req.raddr),
        .rdata (pos_rdata)
    );

    // Sample memory
    ssr_ram #(
        .WIDTH (ssr_pkg::WORD_W),
        .DEPTH (ssr_pkg::SAMPLE_DEPTH)
    ) u_smp_ram (
        .clk   (clk),
        .we    (smp_req.we),
        .waddr (smp_req.waddr),
        .wdata (smp_req.wdata),
        .re    (smp_req.re),
        .raddr (smp_req.raddr),
        .rdata (smp_rdata)
    );

    // Back end never pops an empty queue
    `SSR_ASSERT_IMPL(a_pop_has_head, q_pop, q_head_valid, "queue popped while empty")
    // Divider is only started when idle, and is busy the cycle after
    `SSR_ASSERT_IMPL(a_start_idle, div_start, !div_status.busy, "divider restarted while busy")
    `SSR_ASSERT_NEXT(a_start_busy, div_start, div_status.busy, "divider failed to start")
    // Completion flag only once the iterations have stopped
    `SSR_ASSERT_IMPL(a_done_idle, div_status.done, !div_status.busy, "divider done while busy")

endmodule
